>>> hw/rtl/i2cw_pkg.sv
package i2cw_pkg;

	localparam int unsigned StepCount = 23;

	// One code for each step of the pin-write program.
	typedef enum logic [StepCount-1:0] {
		ST_START_SDA_HI = 23'(1) << 0,
		ST_START_SCL_HI = 23'(1) << 1,
		ST_START_WAIT_A = 23'(1) << 2,
		ST_START_SDA_LO = 23'(1) << 3,
		ST_START_SCL_LO = 23'(1) << 4,
		ST_START_WAIT_B = 23'(1) << 5,
		ST_BIT_SCL_LO   = 23'(1) << 6,
		ST_BIT_SDA      = 23'(1) << 7,
		ST_BIT_WAIT_A   = 23'(1) << 8,
		ST_BIT_SCL_HI   = 23'(1) << 9,
		ST_BIT_WAIT_B   = 23'(1) << 10,
		ST_ACK_SCL_LO   = 23'(1) << 11,
		ST_ACK_WAIT_A   = 23'(1) << 12,
		ST_ACK_SCL_HI   = 23'(1) << 13,
		ST_ACK_WAIT_B   = 23'(1) << 14,
		ST_ACK_SCL_END  = 23'(1) << 15,
		ST_ACK_WAIT_C   = 23'(1) << 16,
		ST_STOP_SCL_HI  = 23'(1) << 17,
		ST_STOP_WAIT_A  = 23'(1) << 18,
		ST_STOP_SCL_LO  = 23'(1) << 19,
		ST_STOP_SDA_HI  = 23'(1) << 20,
		ST_STOP_WAIT_B  = 23'(1) << 21,
		ST_FINISHED     = 23'(1) << 22
	} step_t;

	typedef enum logic {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_HALF_PERIOD    = 1'b1
	} reg_index_t;

	localparam logic [7:0] CTRL_DATA = 8'h40;
	localparam logic [7:0] CTRL_CMD  = 8'h00;
	localparam logic [2:0] BIT_LAST  = 3'd7;
	localparam logic [1:0] BYTE_LAST = 2'd2;

	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd120;
	localparam logic [9:0] HALF_PERIOD_RESET    = 10'd2;

	typedef struct packed {
		logic       is_data;
		logic [7:0] data_byte;
		logic       req_type;
	} item_t;

	// Packed so that scl_level sits in the lowest bit.
	typedef struct packed {
		logic done_res;
		logic accepted;
		logic busy_res;
		logic sda_level;
		logic scl_level;
	} res_t;

endpackage

>>> hw/rtl/i2cw_engine.sv
module i2cw_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  i2cw_pkg::item_t  item,
	input  logic [7:0]       device_address,
	input  logic [9:0]       half_period_ticks,
	output i2cw_pkg::res_t   res
);

	i2cw_pkg::step_t step_q, step_n;
	logic [9:0] wait_q, wait_n;
	logic [7:0] shift_q, shift_n;
	logic [1:0] byte_q, byte_n;
	logic [2:0] bit_q, bit_n;
	logic [7:0] payload_q, payload_n;
	logic       is_data_q, is_data_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       active_q, active_n;
	logic       acc;
	logic       done;
	logic [9:0] wait_load;

	// A half period of zero behaves as one tick.
	assign wait_load = (half_period_ticks == 10'd0) ? 10'd0 : half_period_ticks - 10'd1;

	always_comb begin
		step_n    = step_q;
		wait_n    = wait_q;
		shift_n   = shift_q;
		byte_n    = byte_q;
		bit_n     = bit_q;
		payload_n = payload_q;
		is_data_n = is_data_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		active_n  = active_q;
		acc       = 1'b0;
		done      = 1'b0;
		if (item_valid) begin
			if (item.req_type) begin
				if (!active_q) begin
					payload_n = item.data_byte;
					is_data_n = item.is_data;
					shift_n   = device_address;
					byte_n    = 2'd0;
					bit_n     = 3'd0;
					step_n    = i2cw_pkg::ST_START_SDA_HI;
					wait_n    = 10'd0;
					active_n  = 1'b1;
					acc       = 1'b1;
				end
			end else if (active_q) begin
				if (wait_q != 10'd0) begin
					wait_n = wait_q - 10'd1;
				end else begin
					case (step_q)
						i2cw_pkg::ST_START_SDA_HI: begin
							sda_n  = 1'b1;
							step_n = i2cw_pkg::ST_START_SCL_HI;
						end
						i2cw_pkg::ST_START_SCL_HI: begin
							scl_n  = 1'b1;
							step_n = i2cw_pkg::ST_START_WAIT_A;
						end
						i2cw_pkg::ST_START_WAIT_A: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_START_SDA_LO;
						end
						i2cw_pkg::ST_START_SDA_LO: begin
							sda_n  = 1'b0;
							step_n = i2cw_pkg::ST_START_SCL_LO;
						end
						i2cw_pkg::ST_START_SCL_LO: begin
							scl_n  = 1'b0;
							step_n = i2cw_pkg::ST_START_WAIT_B;
						end
						i2cw_pkg::ST_START_WAIT_B: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_BIT_SCL_LO;
						end
						i2cw_pkg::ST_BIT_SCL_LO: begin
							scl_n  = 1'b0;
							step_n = i2cw_pkg::ST_BIT_SDA;
						end
						i2cw_pkg::ST_BIT_SDA: begin
							sda_n  = shift_q[7];
							step_n = i2cw_pkg::ST_BIT_WAIT_A;
						end
						i2cw_pkg::ST_BIT_WAIT_A: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_BIT_SCL_HI;
						end
						i2cw_pkg::ST_BIT_SCL_HI: begin
							scl_n  = 1'b1;
							step_n = i2cw_pkg::ST_BIT_WAIT_B;
						end
						i2cw_pkg::ST_BIT_WAIT_B: begin
							shift_n = {shift_q[6:0], 1'b0};
							wait_n  = wait_load;
							if (bit_q == i2cw_pkg::BIT_LAST) begin
								bit_n  = 3'd0;
								step_n = i2cw_pkg::ST_ACK_SCL_LO;
							end else begin
								bit_n  = bit_q + 3'd1;
								step_n = i2cw_pkg::ST_BIT_SCL_LO;
							end
						end
						i2cw_pkg::ST_ACK_SCL_LO: begin
							scl_n  = 1'b0;
							step_n = i2cw_pkg::ST_ACK_WAIT_A;
						end
						i2cw_pkg::ST_ACK_WAIT_A: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_ACK_SCL_HI;
						end
						i2cw_pkg::ST_ACK_SCL_HI: begin
							scl_n  = 1'b1;
							step_n = i2cw_pkg::ST_ACK_WAIT_B;
						end
						i2cw_pkg::ST_ACK_WAIT_B: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_ACK_SCL_END;
						end
						i2cw_pkg::ST_ACK_SCL_END: begin
							scl_n  = 1'b0;
							step_n = i2cw_pkg::ST_ACK_WAIT_C;
						end
						i2cw_pkg::ST_ACK_WAIT_C: begin
							wait_n = wait_load;
							if (byte_q >= i2cw_pkg::BYTE_LAST) begin
								byte_n = 2'd0;
								step_n = i2cw_pkg::ST_STOP_SCL_HI;
							end else begin
								byte_n = byte_q + 2'd1;
								if (byte_q == 2'd0) begin
									shift_n = is_data_q ? i2cw_pkg::CTRL_DATA
									                    : i2cw_pkg::CTRL_CMD;
								end else begin
									shift_n = payload_q;
								end
								step_n = i2cw_pkg::ST_BIT_SCL_LO;
							end
						end
						i2cw_pkg::ST_STOP_SCL_HI: begin
							scl_n  = 1'b1;
							step_n = i2cw_pkg::ST_STOP_WAIT_A;
						end
						i2cw_pkg::ST_STOP_WAIT_A: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_STOP_SCL_LO;
						end
						i2cw_pkg::ST_STOP_SCL_LO: begin
							scl_n  = 1'b0;
							step_n = i2cw_pkg::ST_STOP_SDA_HI;
						end
						i2cw_pkg::ST_STOP_SDA_HI: begin
							sda_n  = 1'b1;
							step_n = i2cw_pkg::ST_STOP_WAIT_B;
						end
						i2cw_pkg::ST_STOP_WAIT_B: begin
							wait_n = wait_load;
							step_n = i2cw_pkg::ST_FINISHED;
						end
						default: begin
							active_n = 1'b0;
							step_n   = i2cw_pkg::ST_START_SDA_HI;
							wait_n   = 10'd0;
						end
					endcase
				end
				if (active_n && step_n == i2cw_pkg::ST_FINISHED && wait_n == 10'd0) begin
					done     = 1'b1;
					active_n = 1'b0;
					step_n   = i2cw_pkg::ST_START_SDA_HI;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= i2cw_pkg::ST_START_SDA_HI;
			wait_q    <= 10'd0;
			shift_q   <= 8'd0;
			byte_q    <= 2'd0;
			bit_q     <= 3'd0;
			payload_q <= 8'd0;
			is_data_q <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			active_q  <= 1'b0;
		end else begin
			step_q    <= step_n;
			wait_q    <= wait_n;
			shift_q   <= shift_n;
			byte_q    <= byte_n;
			bit_q     <= bit_n;
			payload_q <= payload_n;
			is_data_q <= is_data_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			active_q  <= active_n;
		end
	end

	assign res.scl_level = scl_n;
	assign res.sda_level = sda_n;
	assign res.busy_res  = active_n;
	assign res.accepted  = acc;
	assign res.done_res  = done;

	// The wait counter is only loaded while a transaction runs.
	a_idle_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> wait_q == 10'd0)
		else $error("wait counter nonzero while idle");

	a_end_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && active_q && !active_n |-> done)
		else $error("transaction ended without done");

	// The stop sequence leaves the clock pin low and the data pin high.
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !active_q && !scl_q && sda_q)
		else $error("pins not left at stop levels after done");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> active_q && step_q == i2cw_pkg::ST_START_SDA_HI
			&& shift_q == $past(device_address))
		else $error("start request not latched correctly");

endmodule

>>> hw/rtl/i2c_display_byte_writer.sv
// Bit-banged I2C write of one byte to a display controller. Each input transfer is either a
// start request (tuser[0] = 1, tdata = payload byte, tuser[1] = 1 for a data byte or 0 for a
// command) or one tick of time (tuser[0] = 0), and each input transfer yields exactly one
// output transfer with the clock and data pin levels, busy, accepted and done. A start request
// while busy is ignored. Each item moves the program sequencer by at most one step, so one
// transfer per cycle is sustained while the output does not stall; a two-entry output buffer
// lets input take one more transfer while the output side stalls. One write sends the device
// address, control byte 0x40 or 0x00 and payload, each wait lasting half_period_ticks ticks.
module i2c_display_byte_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // data_byte
	input  logic [1:0] s_axis_tuser,  // req_type, is_data
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // scl_level, sda_level, busy_res, accepted, done_res, zeros
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data
);

	logic [7:0]      device_address_q;
	logic [9:0]      half_period_q;
	logic            in_xfer;
	logic            out_xfer;
	i2cw_pkg::item_t item;
	i2cw_pkg::res_t  res;
	i2cw_pkg::res_t  out_q;
	i2cw_pkg::res_t  skid_q;
	logic            out_valid_q;
	logic            skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= i2cw_pkg::DEVICE_ADDRESS_RESET;
			half_period_q    <= i2cw_pkg::HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			case (i2cw_pkg::reg_index_t'(cfg_index))
				i2cw_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg_data[7:0];
				i2cw_pkg::REG_HALF_PERIOD:    half_period_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;

	assign item.req_type  = s_axis_tuser[0];
	assign item.is_data   = s_axis_tuser[1];
	assign item.data_byte = s_axis_tdata;

	i2cw_engine u_engine (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (in_xfer),
		.item              (item),
		.device_address    (device_address_q),
		.half_period_ticks (half_period_q),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_xfer) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_xfer) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_xfer) begin
				out_q <= res;
			end
		end else if (in_xfer) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_xfer |=> out_valid_q && !skid_valid_q && out_q == $past(skid_q))
		else $error("skid entry not moved to output");

endmodule

>>> sim/i2c_pin_checker.sv
module i2c_pin_checker
	import i2cw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	output int unsigned fail_count,
	output int unsigned backlog
);

	logic [7:0] dev_addr;
	logic [9:0] half_ticks;
	step_t      cur_step;
	logic [9:0] hold_left;
	logic [7:0] out_byte;
	logic [1:0] byte_count;
	logic [2:0] bit_count;
	logic [7:0] held_payload;
	logic       held_is_data;
	logic       pin_scl;
	logic       pin_sda;
	logic       xfer_active;
	res_t       expected_pins[$];

	// A wait of zero ticks is stretched to one.
	task automatic start_hold(input step_t next_step);
		hold_left = (half_ticks == '0) ? 10'd0 : half_ticks - 10'd1;
		cur_step = next_step;
	endtask

	task automatic run_program_step();
		case (cur_step)
			ST_START_SDA_HI: begin
				pin_sda = 1'b1;
				cur_step = ST_START_SCL_HI;
			end
			ST_START_SCL_HI: begin
				pin_scl = 1'b1;
				cur_step = ST_START_WAIT_A;
			end
			ST_START_WAIT_A: start_hold(ST_START_SDA_LO);
			ST_START_SDA_LO: begin
				pin_sda = 1'b0;
				cur_step = ST_START_SCL_LO;
			end
			ST_START_SCL_LO: begin
				pin_scl = 1'b0;
				cur_step = ST_START_WAIT_B;
			end
			ST_START_WAIT_B: start_hold(ST_BIT_SCL_LO);
			ST_BIT_SCL_LO: begin
				pin_scl = 1'b0;
				cur_step = ST_BIT_SDA;
			end
			ST_BIT_SDA: begin
				pin_sda = out_byte[7];
				cur_step = ST_BIT_WAIT_A;
			end
			ST_BIT_WAIT_A: start_hold(ST_BIT_SCL_HI);
			ST_BIT_SCL_HI: begin
				pin_scl = 1'b1;
				cur_step = ST_BIT_WAIT_B;
			end
			ST_BIT_WAIT_B: begin
				out_byte = {out_byte[6:0], 1'b0};
				if (bit_count == BIT_LAST) begin
					bit_count = '0;
					start_hold(ST_ACK_SCL_LO);
				end else begin
					bit_count = bit_count + 3'd1;
					start_hold(ST_BIT_SCL_LO);
				end
			end
			ST_ACK_SCL_LO: begin
				pin_scl = 1'b0;
				cur_step = ST_ACK_WAIT_A;
			end
			ST_ACK_WAIT_A: start_hold(ST_ACK_SCL_HI);
			ST_ACK_SCL_HI: begin
				pin_scl = 1'b1;
				cur_step = ST_ACK_WAIT_B;
			end
			ST_ACK_WAIT_B: start_hold(ST_ACK_SCL_END);
			ST_ACK_SCL_END: begin
				pin_scl = 1'b0;
				cur_step = ST_ACK_WAIT_C;
			end
			ST_ACK_WAIT_C: begin
				if (byte_count >= BYTE_LAST) begin
					byte_count = '0;
					start_hold(ST_STOP_SCL_HI);
				end else begin
					byte_count = byte_count + 2'd1;
					if (byte_count == 2'd1) begin
						out_byte = held_is_data ? CTRL_DATA : CTRL_CMD;
					end else begin
						out_byte = held_payload;
					end
					start_hold(ST_BIT_SCL_LO);
				end
			end
			ST_STOP_SCL_HI: begin
				pin_scl = 1'b1;
				cur_step = ST_STOP_WAIT_A;
			end
			ST_STOP_WAIT_A: start_hold(ST_STOP_SCL_LO);
			ST_STOP_SCL_LO: begin
				pin_scl = 1'b0;
				cur_step = ST_STOP_SDA_HI;
			end
			ST_STOP_SDA_HI: begin
				pin_sda = 1'b1;
				cur_step = ST_STOP_WAIT_B;
			end
			ST_STOP_WAIT_B: start_hold(ST_FINISHED);
			default: begin
				xfer_active = 1'b0;
				cur_step = ST_START_SDA_HI;
				hold_left = '0;
			end
		endcase
	endtask

	task automatic advance_writer(input item_t it, output res_t r);
		r = '0;
		if (it.req_type) begin
			if (!xfer_active) begin
				held_payload = it.data_byte;
				held_is_data = it.is_data;
				out_byte = dev_addr;
				byte_count = '0;
				bit_count = '0;
				cur_step = ST_START_SDA_HI;
				hold_left = '0;
				xfer_active = 1'b1;
				r.accepted = 1'b1;
			end
		end else if (xfer_active) begin
			if (hold_left != '0) begin
				hold_left = hold_left - 10'd1;
			end else begin
				run_program_step();
			end
			if (xfer_active && cur_step == ST_FINISHED && hold_left == '0) begin
				r.done_res = 1'b1;
				xfer_active = 1'b0;
				cur_step = ST_START_SDA_HI;
			end
		end
		r.scl_level = pin_scl;
		r.sda_level = pin_sda;
		r.busy_res = xfer_active;
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		item_t it;
		res_t  want;
		res_t  got;
		if (!arst_n) begin
			dev_addr = DEVICE_ADDRESS_RESET;
			half_ticks = HALF_PERIOD_RESET;
			cur_step = ST_START_SDA_HI;
			hold_left = '0;
			out_byte = '0;
			byte_count = '0;
			bit_count = '0;
			held_payload = '0;
			held_is_data = 1'b0;
			pin_scl = 1'b1;
			pin_sda = 1'b1;
			xfer_active = 1'b0;
			expected_pins.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_DEVICE_ADDRESS: dev_addr = cfg_data[7:0];
					REG_HALF_PERIOD:    half_ticks = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				it.req_type = s_axis_tuser[0];
				it.is_data = s_axis_tuser[1];
				it.data_byte = s_axis_tdata;
				advance_writer(it, want);
				expected_pins.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[4:0]);
				if (expected_pins.size() == 0) begin
					$error("Output transfer with nothing expected: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_pins.pop_front();
					check_field("scl_level", want.scl_level, got.scl_level);
					check_field("sda_level", want.sda_level, got.sda_level);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("accepted", want.accepted, got.accepted);
					check_field("done_res", want.done_res, got.done_res);
				end
			end
		end
		backlog = expected_pins.size();
	end

endmodule

>>> sim/tb_i2c_display_byte_writer.sv
module tb_i2c_display_byte_writer;
	import i2cw_pkg::*;

	localparam int unsigned CycleLimit = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_DEVICE_ADDRESS;
	logic [9:0]  cfg_data = '0;
	int unsigned fail_count;
	int unsigned backlog;
	int unsigned cycle_count = 0;
	int unsigned sent_items = 0;
	bit          steady = 1'b0;
	bit          sink_hold = 1'b0;

	i2c_display_byte_writer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	i2c_pin_checker pin_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.backlog       (backlog)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	// Ticks of a complete write for a given wait length.
	function automatic int write_ticks(input logic [9:0] half);
		return 88 + 61 * ((half == '0) ? 1 : int'(half));
	endfunction

	task automatic send_item(input logic req, input logic [7:0] val, input logic flag);
		int gap;
		gap = pick_gap(steady);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		s_axis_tuser  <= {flag, req};
		sent_items++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_tick();
		send_item(1'b0, 8'($urandom), 1'($urandom));
	endtask

	// A start request, then ticks with an occasional start request while busy.
	task automatic run_write(input logic [7:0] payload, input logic flag, input int ticks,
		input int busy_pct);
		send_item(1'b1, payload, flag);
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 99) < busy_pct) begin
				send_item(1'b1, 8'($urandom), 1'($urandom));
			end
			send_tick();
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (backlog == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [9:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : sink
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				sink_hold = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				stall = pick_gap(steady);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [7:0]  addr_set [4];
		logic [9:0]  half_set [4];
		int unsigned phase_end;
		int          nominal;
		int          n;
		addr_set = '{8'($urandom), 8'h00, 8'hFF, 8'h78};
		half_set = '{10'd1, 10'd2, 10'd3, 10'd0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick();
		send_item(1'b1, 8'hFF, 1'b1);
		send_item(1'b1, 8'h00, 1'b0);
		repeat (write_ticks(HALF_PERIOD_RESET) + 3) send_tick();

		for (int p = 0; p < 4; p++) begin
			drain();
			write_reg(REG_DEVICE_ADDRESS, {2'b00, addr_set[p]});
			write_reg(REG_HALF_PERIOD, half_set[p]);
			nominal = write_ticks(half_set[p]);
			phase_end = sent_items + 100;
			steady = (p == 3);
			if (p == 1) begin
				sink_hold = 1'b1;
				steady = 1'b1;
				run_write(8'($urandom), 1'($urandom), nominal + 2, 2);
				steady = 1'b0;
			end
			if (p == 2) begin
				run_write(8'($urandom), 1'($urandom), nominal + 1, 2);
				drain();
			end
			while (sent_items < phase_end) begin
				if ($urandom_range(0, 99) < 15) begin
					n = $urandom_range(5, nominal);
				end else begin
					n = nominal + $urandom_range(0, 6);
				end
				run_write(8'($urandom), 1'($urandom), n, 2);
			end
		end

		// Longest wait: start a write and run part way into its first wait.
		drain();
		write_reg(REG_DEVICE_ADDRESS, 10'h0FF);
		write_reg(REG_HALF_PERIOD, 10'd1023);
		steady = 1'b1;
		send_item(1'b1, 8'($urandom), 1'($urandom));
		repeat (40) send_tick();
		steady = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && backlog == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
